[hw/rtl/arsq_pkg.sv]
// Shared types, codes and widths for the auto-recloser sequencer.
package arsq_pkg;

    localparam int TIMER_BITS = 20;
    localparam int COUNT_BITS = 4;
    localparam int CFG_BITS   = 20;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Item kinds.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_TRIP = 2'd1;
    localparam logic [1:0] KIND_POS  = 2'd2;

    // Trip stages.
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_TRIPPED = 2'd1;
    localparam logic [1:0] ST_OPEN    = 2'd2;

    // Breaker positions.
    localparam logic [1:0] POS_INTER  = 2'd0;
    localparam logic [1:0] POS_OPEN   = 2'd1;
    localparam logic [1:0] POS_CLOSED = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESP_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RECLOSE_DLY  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REARM_DLY    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_RECLOSES = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [TIMER_BITS-1:0] RESP_TIMEOUT_RST = 20'd10000;
    localparam logic [TIMER_BITS-1:0] RECLOSE_DLY_RST  = 20'd3000;
    localparam logic [TIMER_BITS-1:0] REARM_DLY_RST    = 20'd60000;
    localparam logic [COUNT_BITS-1:0] MAX_RECLOSES_RST = 4'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic       value_present;
        logic       trip_active;
        logic [1:0] breaker_position;
    } t_item;

    typedef struct packed {
        logic [TIMER_BITS-1:0] response_timeout;
        logic [TIMER_BITS-1:0] reclose_delay;
        logic [TIMER_BITS-1:0] rearm_delay;
        logic [COUNT_BITS-1:0] max_recloses;
    } t_cfg;

    typedef struct packed {
        logic                  close_command;
        logic                  lockout_event;
        logic                  timeout_event;
        logic [1:0]            trip_stage;
        logic [COUNT_BITS-1:0] reclose_count;
    } t_result;

endpackage

[hw/rtl/arsq_timer.sv]
// Down-counting delay timer with start, tick and expiry.
module arsq_timer
    import arsq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  logic                  i_start,
    input  logic [TIMER_BITS-1:0] i_delay,
    output logic                  o_expire
);

    logic                  r_run;
    logic [TIMER_BITS-1:0] r_cnt;

    // A count of zero or one expires on the next tick, so a delay of zero acts like one.
    assign o_expire = i_tick && r_run && (r_cnt <= TIMER_BITS'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_tick && r_run) begin
            if (o_expire) begin
                r_run <= 1'b0;
            end
        end else if (i_start && !r_run) begin
            r_run <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick && r_run) begin
            if (o_expire) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt - TIMER_BITS'(1);
            end
        end else if (i_start && !r_run) begin
            r_cnt <= i_delay;
        end
    end

`ifndef SYNTHESIS
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !i_tick |=> r_run)
        else $error("timer not running after start");
    a_expire_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_expire |=> !r_run)
        else $error("timer still running after expiry");
`endif

endmodule

[hw/rtl/arsq_core.sv]
// Sequencer state, its three timers and the per-item update logic.
module arsq_core
    import arsq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    logic [1:0]            r_stage;
    logic [COUNT_BITS-1:0] r_count;
    logic [1:0]            r_last_pos;
    logic                  r_pos_known;

    logic [1:0]            n_stage;
    logic [COUNT_BITS-1:0] n_count;
    logic [1:0]            n_last_pos;
    logic                  n_pos_known;

    logic tick;
    logic start_to, start_rc, start_ra;
    logic exp_to, exp_rc, exp_ra;
    logic close_cmd, lockout, tout;

    assign tick = i_en && (i_item.kind == KIND_TICK);

    arsq_timer u_timeout (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_start  (start_to),
        .i_delay  (i_cfg.response_timeout),
        .o_expire (exp_to)
    );

    arsq_timer u_reclose (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_start  (start_rc),
        .i_delay  (i_cfg.reclose_delay),
        .o_expire (exp_rc)
    );

    arsq_timer u_rearm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick),
        .i_start  (start_ra),
        .i_delay  (i_cfg.rearm_delay),
        .o_expire (exp_ra)
    );

    always_comb begin
        n_stage     = r_stage;
        n_count     = r_count;
        n_last_pos  = r_last_pos;
        n_pos_known = r_pos_known;
        start_to    = 1'b0;
        start_rc    = 1'b0;
        start_ra    = 1'b0;
        close_cmd   = 1'b0;
        lockout     = 1'b0;
        tout        = 1'b0;

        case (i_item.kind)
            KIND_TICK: begin
                // Expiries in one tick are handled timeout, reclose, rearm.
                if (exp_to && n_stage == ST_TRIPPED) begin
                    n_stage = ST_IDLE;
                    tout    = 1'b1;
                end
                if (exp_rc && n_stage == ST_OPEN && r_pos_known &&
                    r_last_pos == POS_OPEN) begin
                    close_cmd = 1'b1;
                    if (n_count != COUNT_MAX) begin
                        n_count = n_count + COUNT_BITS'(1);
                    end
                    n_stage = ST_IDLE;
                end
                if (exp_ra && (n_stage != ST_IDLE || n_count != '0) && r_pos_known &&
                    r_last_pos == POS_CLOSED) begin
                    n_stage = ST_IDLE;
                    n_count = '0;
                end
            end
            KIND_TRIP: begin
                if (i_item.value_present && i_item.trip_active && r_stage == ST_IDLE) begin
                    n_stage  = ST_TRIPPED;
                    start_to = i_en;
                end
            end
            KIND_POS: begin
                if (i_item.value_present) begin
                    n_last_pos  = i_item.breaker_position;
                    n_pos_known = 1'b1;
                    if (r_stage == ST_TRIPPED && i_item.breaker_position == POS_OPEN) begin
                        if (r_count < i_cfg.max_recloses) begin
                            n_stage  = ST_OPEN;
                            start_rc = i_en;
                        end else begin
                            lockout = 1'b1;
                            if (n_count != COUNT_MAX) begin
                                n_count = n_count + COUNT_BITS'(1);
                            end
                            n_stage = ST_IDLE;
                        end
                    end
                    if ((n_stage != ST_IDLE || n_count != '0) &&
                        i_item.breaker_position == POS_CLOSED) begin
                        start_ra = i_en;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= ST_IDLE;
            r_count     <= '0;
            r_last_pos  <= POS_INTER;
            r_pos_known <= 1'b0;
        end else if (i_en) begin
            r_stage     <= n_stage;
            r_count     <= n_count;
            r_last_pos  <= n_last_pos;
            r_pos_known <= n_pos_known;
        end
    end

    assign o_res.close_command = close_cmd;
    assign o_res.lockout_event = lockout;
    assign o_res.timeout_event = tout;
    assign o_res.trip_stage    = n_stage;
    assign o_res.reclose_count = n_count;

`ifndef SYNTHESIS
    a_close_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && close_cmd |=> r_count != '0)
        else $error("close command issued without counting the attempt");
    a_timeout_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && tout |=> r_stage == ST_IDLE)
        else $error("timeout left the stage busy");
    a_trip_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.kind == KIND_TRIP && i_item.value_present &&
        i_item.trip_active && r_stage == ST_IDLE |=> r_stage == ST_TRIPPED)
        else $error("trip while idle did not enter the tripped stage");
`endif

endmodule

[hw/rtl/auto_recloser_sequencer.sv]
// Top level of the auto-recloser sequencer: handshakes, configuration and result register.
//
//  channel   direction  handshake            beat contents
//  input     in         i_valid / o_stall    i_kind, i_value_present, i_trip_active,
//                                            i_breaker_position
//  result    out        o_valid / i_stall    o_close_command, o_lockout_event,
//                                            o_timeout_event, o_trip_stage, o_reclose_count
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// Every input beat yields one result beat, passed through the input and result registers.
// One beat is taken each cycle while o_stall is low; the state update is combinational.
// The input register and the result register decouple the sides, so a new beat is
// taken while a finished result waits; o_stall rises only when both are full and
// the result side stalls.
// Synchronous reset clears the stage, count, timers and configuration to defaults.
module auto_recloser_sequencer
    import arsq_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [1:0]              i_kind,
    input  logic                    i_value_present,
    input  logic                    i_trip_active,
    input  logic [1:0]              i_breaker_position,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_close_command,
    output logic                    o_lockout_event,
    output logic                    o_timeout_event,
    output logic [1:0]              o_trip_stage,
    output logic [COUNT_BITS-1:0]   o_reclose_count,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    logic    r_in_vld;
    t_item   r_item;
    logic    r_out_vld;
    t_result r_res;
    t_cfg    r_cfg;

    logic    adv;
    logic    process;
    logic    accept;
    t_result res;

    assign adv     = !r_out_vld || !i_stall;
    assign process = r_in_vld && adv;
    assign o_stall = r_in_vld && !adv;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.response_timeout <= RESP_TIMEOUT_RST;
            r_cfg.reclose_delay    <= RECLOSE_DLY_RST;
            r_cfg.rearm_delay      <= REARM_DLY_RST;
            r_cfg.max_recloses     <= MAX_RECLOSES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RESP_TIMEOUT: r_cfg.response_timeout <= i_cfg_data[TIMER_BITS-1:0];
                CFG_RECLOSE_DLY:  r_cfg.reclose_delay    <= i_cfg_data[TIMER_BITS-1:0];
                CFG_REARM_DLY:    r_cfg.rearm_delay      <= i_cfg_data[TIMER_BITS-1:0];
                CFG_MAX_RECLOSES: r_cfg.max_recloses     <= i_cfg_data[COUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (process) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind             <= i_kind;
            r_item.value_present    <= i_value_present;
            r_item.trip_active      <= i_trip_active;
            r_item.breaker_position <= i_breaker_position;
        end
    end

    arsq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (process),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (process) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_res <= res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_close_command = r_res.close_command;
    assign o_lockout_event = r_res.lockout_event;
    assign o_timeout_event = r_res.timeout_event;
    assign o_trip_stage    = r_res.trip_stage;
    assign o_reclose_count = r_res.reclose_count;

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_vld && r_out_vld && i_stall)
        else $error("input stalled while a register was free");
`endif

endmodule

[dv/tb_auto_recloser_sequencer.sv]
// Testbench for the auto-recloser sequencer: directed and random beats checked against a predictor.
module tb_auto_recloser_sequencer;
    import arsq_pkg::*;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [1:0] POS_BAD      = 2'd3;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         MAX_WAIT     = 16;
    localparam logic [CFG_BITS-1:0] DELAY_MAX = '1;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic [1:0]              i_kind = KIND_TICK;
    logic                    i_value_present = 1'b0;
    logic                    i_trip_active = 1'b0;
    logic [1:0]              i_breaker_position = POS_INTER;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic                    o_close_command;
    logic                    o_lockout_event;
    logic                    o_timeout_event;
    logic [1:0]              o_trip_stage;
    logic [COUNT_BITS-1:0]   o_reclose_count;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = CFG_RESP_TIMEOUT;
    logic [CFG_BITS-1:0]     i_cfg_data = '0;

    auto_recloser_sequencer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_value_present    (i_value_present),
        .i_trip_active      (i_trip_active),
        .i_breaker_position (i_breaker_position),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_close_command    (o_close_command),
        .o_lockout_event    (o_lockout_event),
        .o_timeout_event    (o_timeout_event),
        .o_trip_stage       (o_trip_stage),
        .o_reclose_count    (o_reclose_count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    // Predicted configuration and recloser state.
    logic [TIMER_BITS-1:0] cfg_resp  = RESP_TIMEOUT_RST;
    logic [TIMER_BITS-1:0] cfg_recl  = RECLOSE_DLY_RST;
    logic [TIMER_BITS-1:0] cfg_rearm = REARM_DLY_RST;
    logic [COUNT_BITS-1:0] cfg_max   = MAX_RECLOSES_RST;

    logic [1:0]            rcl_stage     = ST_IDLE;
    logic [COUNT_BITS-1:0] rcl_count     = '0;
    logic [1:0]            rcl_last_pos  = POS_INTER;
    logic                  rcl_pos_known = 1'b0;
    logic [TIMER_BITS-1:0] tmr_resp      = '0;
    logic [TIMER_BITS-1:0] tmr_recl      = '0;
    logic [TIMER_BITS-1:0] tmr_rearm     = '0;
    logic                  run_resp      = 1'b0;
    logic                  run_recl      = 1'b0;
    logic                  run_rearm     = 1'b0;

    t_result pending_results[$];
    int      n_errors    = 0;
    int      n_effective = 0;
    bit      tx_no_gap   = 1'b0;
    bit      rx_no_stall = 1'b0;
    int      rx_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic logic timer_expires(inout logic [TIMER_BITS-1:0] cnt, inout logic run);
        if (!run) return 1'b0;
        if (cnt <= 1) begin
            cnt = '0;
            run = 1'b0;
            return 1'b1;
        end
        cnt = cnt - 1'b1;
        return 1'b0;
    endfunction

    // A start while the timer runs leaves its count alone.
    function automatic void timer_start(inout logic [TIMER_BITS-1:0] cnt, inout logic run,
                                        input logic [TIMER_BITS-1:0] delay);
        if (!run) begin
            run = 1'b1;
            cnt = delay;
        end
    endfunction

    function automatic void count_trip();
        if (rcl_count != COUNT_MAX) rcl_count = rcl_count + 1'b1;
    endfunction

    function automatic t_result next_recloser_result(input t_item it);
        t_result r;
        logic    fired;
        r = '0;
        if (it.kind == KIND_TICK) begin
            fired = timer_expires(tmr_resp, run_resp);
            if (fired && rcl_stage == ST_TRIPPED) begin
                rcl_stage = ST_IDLE;
                r.timeout_event = 1'b1;
            end
            fired = timer_expires(tmr_recl, run_recl);
            if (fired && rcl_stage == ST_OPEN && rcl_pos_known && rcl_last_pos == POS_OPEN) begin
                r.close_command = 1'b1;
                count_trip();
                rcl_stage = ST_IDLE;
            end
            fired = timer_expires(tmr_rearm, run_rearm);
            if (fired && (rcl_stage != ST_IDLE || rcl_count != 0) && rcl_pos_known &&
                rcl_last_pos == POS_CLOSED) begin
                rcl_stage = ST_IDLE;
                rcl_count = '0;
            end
        end else if (it.kind == KIND_TRIP && it.value_present) begin
            if (it.trip_active && rcl_stage == ST_IDLE) begin
                rcl_stage = ST_TRIPPED;
                timer_start(tmr_resp, run_resp, cfg_resp);
            end
        end else if (it.kind == KIND_POS && it.value_present) begin
            rcl_last_pos  = it.breaker_position;
            rcl_pos_known = 1'b1;
            if (rcl_stage == ST_TRIPPED && it.breaker_position == POS_OPEN) begin
                rcl_stage = ST_OPEN;
                if (rcl_count < cfg_max) begin
                    timer_start(tmr_recl, run_recl, cfg_recl);
                end else begin
                    r.lockout_event = 1'b1;
                    count_trip();
                    rcl_stage = ST_IDLE;
                end
            end
            if ((rcl_stage != ST_IDLE || rcl_count != 0) && it.breaker_position == POS_CLOSED)
                timer_start(tmr_rearm, run_rearm, cfg_rearm);
        end
        r.trip_stage    = rcl_stage;
        r.reclose_count = rcl_count;
        return r;
    endfunction

    function automatic int draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int tick_span(input logic [TIMER_BITS-1:0] d);
        return (d > 24) ? 25 : int'(d) + 1;
    endfunction

    // Every stimulus task below returns right after a rising edge, so the next one may drive at once.
    task automatic send_beat(input logic [1:0] kind, input logic present, input logic trip,
                             input logic [1:0] pos);
        int    gap;
        t_item it;
        gap = draw_wait(tx_no_gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_kind             <= kind;
        i_value_present    <= present;
        i_trip_active      <= trip;
        i_breaker_position <= pos;
        do @(posedge i_clk); while (o_stall);
        it = '{kind, present, trip, pos};
        pending_results.push_back(next_recloser_result(it));
        if (kind == KIND_TICK || ((kind == KIND_TRIP || kind == KIND_POS) && present))
            n_effective++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(KIND_TICK, 1'($urandom), 1'($urandom), 2'($urandom));
    endtask

    task automatic send_noise();
        send_beat(2'($urandom_range(0, 3)), ($urandom_range(0, 3) != 0), 1'($urandom),
                  2'($urandom));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RESP_TIMEOUT: cfg_resp  = data;
            CFG_RECLOSE_DLY:  cfg_recl  = data;
            CFG_REARM_DLY:    cfg_rearm = data;
            CFG_MAX_RECLOSES: cfg_max   = data[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Only called with the block drained.
    task automatic set_config(input logic [CFG_BITS-1:0] resp, input logic [CFG_BITS-1:0] recl,
                              input logic [CFG_BITS-1:0] rearm, input logic [CFG_BITS-1:0] maxr);
        cfg_write(CFG_RESP_TIMEOUT, resp);
        cfg_write(CFG_RECLOSE_DLY, recl);
        cfg_write(CFG_REARM_DLY, rearm);
        cfg_write(CFG_MAX_RECLOSES, maxr);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Trip, breaker opens, reclose attempt, breaker closes, with random timing and some breakage.
    task automatic run_trip_cycle();
        send_beat(KIND_TRIP, 1'b1, ($urandom_range(0, 7) != 0), 2'($urandom));
        send_ticks($urandom_range(0, tick_span(cfg_resp)));
        if ($urandom_range(0, 7) != 0) send_beat(KIND_POS, 1'b1, 1'($urandom), POS_OPEN);
        else send_noise();
        send_ticks($urandom_range(0, tick_span(cfg_recl)));
        if ($urandom_range(0, 5) != 0) send_beat(KIND_POS, 1'b1, 1'($urandom), POS_CLOSED);
        else send_noise();
        send_ticks($urandom_range(0, tick_span(cfg_rearm)));
    endtask

    task automatic run_random_mix(input int target);
        int start;
        start = n_effective;
        while (n_effective - start < target) begin
            if ($urandom_range(0, 9) < 7) run_trip_cycle();
            else repeat ($urandom_range(1, 8)) send_noise();
        end
    endtask

    task automatic test_ignored_items();
        send_beat(KIND_TICK, 1'b0, 1'b0, POS_INTER);
        send_beat(KIND_UNUSED, 1'b1, 1'b1, POS_BAD);
        send_beat(KIND_UNUSED, 1'b0, 1'b0, POS_INTER);
        send_beat(KIND_TRIP, 1'b0, 1'b1, POS_OPEN);
        send_beat(KIND_POS, 1'b0, 1'b1, POS_OPEN);
        send_beat(KIND_TRIP, 1'b1, 1'b0, POS_INTER);
        send_beat(KIND_POS, 1'b1, 1'b0, POS_CLOSED);
    endtask

    task automatic test_trip_sequence();
        drain();
        // A reclose delay of zero behaves as one tick.
        set_config(20'd2, 20'd0, 20'd3, 20'd1);
        send_beat(KIND_TRIP, 1'b1, 1'b1, POS_INTER);
        send_beat(KIND_TRIP, 1'b1, 1'b1, POS_INTER);
        send_ticks(2);
        send_beat(KIND_TRIP, 1'b1, 1'b1, POS_INTER);
        send_beat(KIND_POS, 1'b1, 1'b0, POS_OPEN);
        send_ticks(2);
        send_beat(KIND_TRIP, 1'b1, 1'b1, POS_INTER);
        send_beat(KIND_POS, 1'b1, 1'b0, POS_OPEN);
        send_beat(KIND_POS, 1'b1, 1'b0, POS_BAD);
        send_beat(KIND_POS, 1'b1, 1'b0, POS_INTER);
        send_beat(KIND_POS, 1'b1, 1'b0, POS_CLOSED);
        // The response timer is still running, so this trip does not restart it.
        send_beat(KIND_TRIP, 1'b1, 1'b1, POS_INTER);
        send_ticks(3);
    endtask

    task automatic test_random_sequences(input int target);
        drain();
        set_config(CFG_BITS'($urandom_range(0, 12)), CFG_BITS'($urandom_range(0, 12)),
                   CFG_BITS'($urandom_range(0, 12)),
                   {16'($urandom), 4'($urandom_range(0, 15))});
        run_random_mix(target);
    endtask

    task automatic test_min_settings();
        drain();
        set_config(20'd1, 20'd1, 20'd1, 20'd0);
        run_random_mix(120);
    endtask

    task automatic test_count_saturation();
        drain();
        set_config(20'd6, 20'd2, 20'd1000, 20'd15);
        run_random_mix(130);
    endtask

    task automatic test_backpressure();
        drain();
        rx_hold_cycles = 60;
        tx_no_gap = 1'b1;
        repeat (40) send_noise();
        tx_no_gap = 1'b0;
    endtask

    task automatic test_long_delays();
        drain();
        set_config(DELAY_MAX, DELAY_MAX, DELAY_MAX, 20'd15);
        run_random_mix(60);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_ignored_items();
        test_trip_sequence();
        test_random_sequences(140);
        tx_no_gap   = 1'b1;
        rx_no_stall = 1'b1;
        test_random_sequences(140);
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;
        test_random_sequences(140);
        test_min_settings();
        test_random_sequences(140);
        test_count_saturation();
        test_backpressure();
        test_long_delays();
        drain();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // Result side stall: a random hold before each beat, or one long hold when asked for.
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                n = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                n = draw_wait(rx_no_stall);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
        end
    end

    task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display({"%0t: result beat with none expected, actual close %0b lockout %0b",
                          " timeout %0b stage %0d count %0d"},
                         $time, o_close_command, o_lockout_event, o_timeout_event,
                         o_trip_stage, o_reclose_count);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("close_command", 4'(want.close_command), 4'(o_close_command));
                check_field("lockout_event", 4'(want.lockout_event), 4'(o_lockout_event));
                check_field("timeout_event", 4'(want.timeout_event), 4'(o_timeout_event));
                check_field("trip_stage", 4'(want.trip_stage), 4'(o_trip_stage));
                check_field("reclose_count", want.reclose_count, o_reclose_count);
            end
        end
    end

endmodule

[auto_recloser_sequencer.f]
hw/rtl/arsq_pkg.sv
hw/rtl/arsq_timer.sv
hw/rtl/arsq_core.sv
hw/rtl/auto_recloser_sequencer.sv
dv/tb_auto_recloser_sequencer.sv
